/* hdl/rtq_pkg.sv */
`timescale 1ns / 1ps

package rtq_pkg;

  localparam int unsigned DEPTH_DEF       = 32;
  localparam int unsigned HANDLE_BITS_DEF = 16;
  localparam int unsigned SEQ_W           = 32;
  localparam int unsigned HDL_W           = 16;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned COUNT_W         = 6;

  // Half the sequence space: the window of the wrap-aware ordering test
  localparam logic [SEQ_W-1:0] WRAP_SPAN = 32'h7FFF_FFFF;

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [HDL_W-1:0]   handle_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_APPENDED     = 2'd0,
    ST_DROPPED      = 2'd1,
    ST_OUT_OF_ORDER = 2'd2,
    ST_RELEASED     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EVICT,
    S_FINAL
  } state_e;

  typedef struct packed {
    cmd_e    cmd;
    seq_t    seq;
    handle_t packet_handle;
    len_t    payload_len;
  } cmd_t;

  typedef struct packed {
    logic    freed_valid;
    handle_t freed_handle;
    seq_t    freed_seq;
    count_t  count;
    status_e status;
    logic    last;
  } res_t;

endpackage

/* hdl/rtq_ram.sv */
`timescale 1ns / 1ps

module rtq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rtq_cmp.sv */
`timescale 1ns / 1ps

// Wrap-aware ordering test: b is not older than a
module rtq_cmp (
  input  rtq_pkg::seq_t a_i,
  input  rtq_pkg::seq_t b_i,
  output logic          not_older_o
);

  rtq_pkg::seq_t a_minus_span;

  assign a_minus_span = a_i - rtq_pkg::WRAP_SPAN;
  assign not_older_o  = (b_i >= a_i) || ((a_i > rtq_pkg::WRAP_SPAN) && (b_i < a_minus_span));

endmodule

/* hdl/retransmit_queue_cumulative_ack.sv */
`timescale 1ns / 1ps

// Retransmission queue with cumulative acknowledgement.
// Command channel: present a beat on cmd_i with start high; it is taken at a rising edge where
// busy is low. An add appends a packet at the tail (evicting the head when full), hands it back
// at once when its sequence or length is zero, or rejects it when older than the tail. A release
// pops every head entry whose sequence is not newer than the acknowledged one.
// Result channel: every freed packet gives one beat on res_o with res_valid_o high for one cycle,
// and each command closes with a beat that has last set and carries count and status. The
// receiver cannot hold results off; it must take each beat in the cycle it is shown.
// Entries sit in a registered-read RAM with one read and one write port, and one wrap-aware
// comparator is reused for the tail test and for every head test. A valid add on an empty
// queue appends straight from idle; a dropped packet closes from the final state; a rejected
// add or a plain append closes from the tail test; a full-queue append runs tail test, head
// read, eviction and closing beat. A release does one RAM read and one compare per pop,
// popping at most DEPTH entries, or closes straight from idle on an empty queue. The closing
// beat is registered and appears once the block is back in idle, while busy is already low.
// Reset: asynchronous and active low; the queue comes up empty with the head at slot zero. The
// entry RAM is not cleared: read data is only ever used from occupied slots.

module retransmit_queue_cumulative_ack #(
  parameter int unsigned DEPTH       = rtq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = rtq_pkg::HANDLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rtq_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          res_valid_o,
  output rtq_pkg::res_t res_o
);

  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned StoreW = (HANDLE_BITS < rtq_pkg::HDL_W) ? HANDLE_BITS : rtq_pkg::HDL_W;
  localparam int unsigned WordW  = rtq_pkg::SEQ_W + StoreW;

  rtq_pkg::state_e  state_q, state_d;
  rtq_pkg::cmd_t    cmd_q;
  rtq_pkg::status_e status_q, status_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  head_q, head_d;
  rtq_pkg::res_t    res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic [SumW-1:0]  sum_app, sum_tail;
  logic [PtrW-1:0]  slot_app, slot_tail, head_inc;

  logic             ram_we;
  logic [PtrW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  rtq_pkg::seq_t    rd_seq;
  logic [StoreW-1:0] rd_hdl;
  rtq_pkg::cmd_t    wr_src;
  logic             not_older;

  assign accept = start && !busy;
  assign busy   = (state_q != rtq_pkg::S_IDLE);

  // Slot arithmetic: sums stay below twice the depth, so one compare and subtract wraps them
  assign sum_app   = SumW'(head_q) + SumW'(cnt_q);
  assign sum_tail  = sum_app - SumW'(1);
  assign slot_app  = (sum_app >= SumW'(DEPTH)) ? PtrW'(sum_app - SumW'(DEPTH)) : PtrW'(sum_app);
  assign slot_tail = (sum_tail >= SumW'(DEPTH)) ? PtrW'(sum_tail - SumW'(DEPTH))
                                                 : PtrW'(sum_tail);
  assign head_inc  = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);

  // Entry word: sequence on top, handle masked to the configured width below
  assign wr_src    = busy ? cmd_q : cmd_i;
  assign ram_wdata = {wr_src.seq, wr_src.packet_handle[StoreW-1:0]};
  assign rd_seq    = ram_rdata[WordW-1 -: rtq_pkg::SEQ_W];
  assign rd_hdl    = ram_rdata[StoreW-1:0];

  rtq_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_app),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One comparator serves both the tail test of an add and each head test of a release
  rtq_cmp u_cmp (
    .a_i         (rd_seq),
    .b_i         (cmd_q.seq),
    .not_older_o (not_older)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    status_d    = status_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    ram_we      = 1'b0;
    ram_raddr   = head_q;

    unique case (state_q)
      rtq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i.cmd == rtq_pkg::CMD_RELEASE) begin
            if (cnt_q == '0) begin
              // Empty queue: close straight away
              res_valid_d  = 1'b1;
              res_d.last   = 1'b1;
              res_d.count  = rtq_pkg::count_t'(cnt_q);
              res_d.status = rtq_pkg::ST_RELEASED;
            end else begin
              state_d = rtq_pkg::S_CHECK;
            end
          end else if ((cmd_i.seq == '0) || (cmd_i.payload_len == '0)) begin
            // Hand the packet straight back, queue untouched
            res_valid_d        = 1'b1;
            res_d.freed_valid  = 1'b1;
            res_d.freed_handle = rtq_pkg::handle_t'(cmd_i.packet_handle[StoreW-1:0]);
            res_d.freed_seq    = cmd_i.seq;
            status_d           = rtq_pkg::ST_DROPPED;
            state_d            = rtq_pkg::S_FINAL;
          end else if (cnt_q == '0) begin
            // Nothing to order against: append now
            ram_we       = 1'b1;
            cnt_d        = CntW'(1);
            res_valid_d  = 1'b1;
            res_d.last   = 1'b1;
            res_d.count  = rtq_pkg::count_t'(1);
            res_d.status = rtq_pkg::ST_APPENDED;
          end else begin
            ram_raddr = slot_tail;
            state_d   = rtq_pkg::S_CHECK;
          end
        end
      end

      rtq_pkg::S_CHECK: begin
        if (cmd_q.cmd == rtq_pkg::CMD_RELEASE) begin
          if (not_older) begin
            // Pop the head and fetch the next one behind it
            res_valid_d        = 1'b1;
            res_d.freed_valid  = 1'b1;
            res_d.freed_handle = rtq_pkg::handle_t'(rd_hdl);
            res_d.freed_seq    = rd_seq;
            head_d             = head_inc;
            cnt_d              = cnt_q - CntW'(1);
            ram_raddr          = head_inc;
            if (cnt_q == CntW'(1)) begin
              status_d = rtq_pkg::ST_RELEASED;
              state_d  = rtq_pkg::S_FINAL;
            end
          end else begin
            res_valid_d  = 1'b1;
            res_d.last   = 1'b1;
            res_d.count  = rtq_pkg::count_t'(cnt_q);
            res_d.status = rtq_pkg::ST_RELEASED;
            state_d      = rtq_pkg::S_IDLE;
          end
        end else if (!not_older) begin
          // Older than the tail: reject
          res_valid_d  = 1'b1;
          res_d.last   = 1'b1;
          res_d.count  = rtq_pkg::count_t'(cnt_q);
          res_d.status = rtq_pkg::ST_OUT_OF_ORDER;
          state_d      = rtq_pkg::S_IDLE;
        end else if (cnt_q == CntW'(DEPTH)) begin
          // Full: read the head for eviction
          ram_raddr = head_q;
          state_d   = rtq_pkg::S_EVICT;
        end else begin
          ram_we       = 1'b1;
          cnt_d        = cnt_q + CntW'(1);
          res_valid_d  = 1'b1;
          res_d.last   = 1'b1;
          res_d.count  = rtq_pkg::count_t'(cnt_q + CntW'(1));
          res_d.status = rtq_pkg::ST_APPENDED;
          state_d      = rtq_pkg::S_IDLE;
        end
      end

      rtq_pkg::S_EVICT: begin
        // Free the old head and overwrite its slot with the new tail
        res_valid_d        = 1'b1;
        res_d.freed_valid  = 1'b1;
        res_d.freed_handle = rtq_pkg::handle_t'(rd_hdl);
        res_d.freed_seq    = rd_seq;
        ram_we             = 1'b1;
        head_d             = head_inc;
        status_d           = rtq_pkg::ST_APPENDED;
        state_d            = rtq_pkg::S_FINAL;
      end

      rtq_pkg::S_FINAL: begin
        res_valid_d  = 1'b1;
        res_d.last   = 1'b1;
        res_d.count  = rtq_pkg::count_t'(cnt_q);
        res_d.status = status_q;
        state_d      = rtq_pkg::S_IDLE;
      end

      default: begin
        state_d = rtq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtq_pkg::S_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
      status_q    <= rtq_pkg::ST_APPENDED;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
    end
  end

  // Payload registers: hold the command beat and the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_final_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("closing beat shown while still busy");

  a_freed_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> (busy && res_o.freed_valid))
    else $error("freed beat outside a command");

  a_final_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtq_pkg::S_FINAL) |=> (res_valid_o && res_o.last))
    else $error("closing beat missing");

  a_write_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != rtq_pkg::S_EVICT)) |-> (cnt_q < CntW'(DEPTH)))
    else $error("append into a full queue without eviction");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QDEPTH = rtq_pkg::DEPTH_DEF;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  rtq_pkg::cmd_t cmd_beat = '0;
  logic          busy;
  logic          res_valid_o;
  rtq_pkg::res_t res_o;

  retransmit_queue_cumulative_ack DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_beat),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Own copy of the queue: sequence and handle per slot, head index and fill level.
  rtq_pkg::seq_t    shadow_seq [QDEPTH];
  rtq_pkg::handle_t shadow_hdl [QDEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_cnt  = 0;

  rtq_pkg::cmd_t cmds_waiting [$];   // commands not yet taken by the block
  rtq_pkg::res_t beats_due    [$];   // result beats still owed by the block, oldest first

  int            mismatches = 0;
  int            idle_left = 0;
  logic          idling_phase = 1'b1;
  rtq_pkg::res_t beat_due;

  // b counts as not older than a when it is ahead, or when it has wrapped past a by less
  // than half the sequence space.
  function automatic bit seq_not_older(rtq_pkg::seq_t a, rtq_pkg::seq_t b);
    return (b >= a) || (a > rtq_pkg::WRAP_SPAN && b < a - rtq_pkg::WRAP_SPAN);
  endfunction

  function automatic void owe_beat(logic fv, rtq_pkg::handle_t h, rtq_pkg::seq_t s,
                                   rtq_pkg::status_e st, logic fin);
    rtq_pkg::res_t r;
    r.freed_valid  = fv;
    r.freed_handle = fv ? h : '0;
    r.freed_seq    = fv ? s : '0;
    r.count        = fin ? rtq_pkg::count_t'(shadow_cnt) : '0;
    r.status       = fin ? st : rtq_pkg::ST_APPENDED;
    r.last         = fin;
    beats_due.push_back(r);
  endfunction

  function automatic void owe_head_free();
    owe_beat(1'b1, shadow_hdl[shadow_head], shadow_seq[shadow_head], rtq_pkg::ST_APPENDED,
             1'b0);
    shadow_head = (shadow_head + 1) % QDEPTH;
    shadow_cnt--;
  endfunction

  // Work out every beat that one accepted command owes, and advance the shadow queue.
  function automatic void ack_queue_step(rtq_pkg::cmd_t c);
    int unsigned slot;
    if (c.cmd == rtq_pkg::CMD_RELEASE) begin
      // Pop from the head while the entry is covered by the cumulative acknowledgement
      while (shadow_cnt > 0 && seq_not_older(shadow_seq[shadow_head], c.seq))
        owe_head_free();
      owe_beat(1'b0, '0, '0, rtq_pkg::ST_RELEASED, 1'b1);
    end else if (c.seq == '0 || c.payload_len == '0) begin
      // Hand the packet straight back; the queue stays as it is
      owe_beat(1'b1, c.packet_handle, c.seq, rtq_pkg::ST_APPENDED, 1'b0);
      owe_beat(1'b0, '0, '0, rtq_pkg::ST_DROPPED, 1'b1);
    end else if (shadow_cnt > 0 && !seq_not_older(
                 shadow_seq[(shadow_head + shadow_cnt - 1) % QDEPTH], c.seq)) begin
      owe_beat(1'b0, '0, '0, rtq_pkg::ST_OUT_OF_ORDER, 1'b1);
    end else begin
      // Tail test passed: evict the head first when full, then append
      if (shadow_cnt >= QDEPTH)
        owe_head_free();
      slot = (shadow_head + shadow_cnt) % QDEPTH;
      shadow_seq[slot] = c.seq;
      shadow_hdl[slot] = c.packet_handle;
      shadow_cnt++;
      owe_beat(1'b0, '0, '0, rtq_pkg::ST_APPENDED, 1'b1);
    end
  endfunction

  function automatic rtq_pkg::cmd_t mk_cmd(rtq_pkg::cmd_e op, rtq_pkg::seq_t s,
                                           rtq_pkg::handle_t h, rtq_pkg::len_t l);
    rtq_pkg::cmd_t c;
    c.cmd           = op;
    c.seq           = s;
    c.packet_handle = h;
    c.payload_len   = l;
    return c;
  endfunction

  // Driver: offer the oldest waiting command, hold it until a beat is taken, and drop start
  // for random bursts while plenty of commands remain.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      cmd_beat  <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        ack_queue_step(cmd_beat);
        void'(cmds_waiting.pop_front());
      end
      if (start && busy) begin
        // hold the beat until the block can take it
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (cmds_waiting.size() == 0) begin
        start <= 1'b0;
      end else if (idling_phase && cmds_waiting.size() > 40 && $urandom_range(0, 3) == 0) begin
        idle_left <= $urandom_range(0, 11);
        start     <= 1'b0;
      end else begin
        start    <= 1'b1;
        cmd_beat <= cmds_waiting[0];
      end
      // Switch between stretches with and without idling now and then
      if ($urandom_range(0, 15) == 0)
        idling_phase <= ~idling_phase;
    end
  end

  // Monitor: every strobed beat must match the oldest beat owed, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with none owed: fv=%0b h=%h s=%h cnt=%0d st=%0d last=%0b",
                   $realtime, res_o.freed_valid, res_o.freed_handle, res_o.freed_seq,
                   res_o.count, res_o.status, res_o.last);
      end else begin
        beat_due = beats_due.pop_front();
        if (res_o.freed_valid !== beat_due.freed_valid ||
            res_o.freed_handle !== beat_due.freed_handle ||
            res_o.freed_seq !== beat_due.freed_seq ||
            res_o.count !== beat_due.count ||
            res_o.status !== beat_due.status ||
            res_o.last !== beat_due.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp fv=%0b h=%h s=%h cnt=%0d st=%0d last=%0b",
                     $realtime, beat_due.freed_valid, beat_due.freed_handle,
                     beat_due.freed_seq, beat_due.count, beat_due.status, beat_due.last);
            $display("%0t:          got fv=%0b h=%h s=%h cnt=%0d st=%0d last=%0b",
                     $realtime, res_o.freed_valid, res_o.freed_handle, res_o.freed_seq,
                     res_o.count, res_o.status, res_o.last);
          end
        end
      end
    end
  end

  initial begin
    rtq_pkg::seq_t run_seq;
    rtq_pkg::seq_t ack_lo;
    rtq_pkg::seq_t step;
    int            made;
    int            run_len;
    bit            first_run;
    logic          op_bit;
    rtq_pkg::seq_t s;

    // Directed: release on an empty queue, zero sequence and zero length drops, appends
    // across the wrap, an out-of-order add, and releases that stop at the wrap window.
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'h0000_0000, 16'h0000, 16'h0000));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0000, 16'hFFFF, 16'h0005));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0005, 16'hA5A5, 16'h0000));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0000, 16'h0000, 16'h0000));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0001, 16'h0000, 16'h0001));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0002, 16'h5A5A, 16'h8000));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h8000_0001, 16'h1234, 16'h0001));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0003, 16'h4321, 16'h0040));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h8000_0001, 16'h0F0F, 16'h7FFF));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'h7FFF_FFFF, 16'h0000, 16'h0000));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 16'h0000, 16'h0001));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 16'h0000, 16'h0001));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h8000_0000, 16'hFFFF, 16'hFFFF));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h7FFF_FFFF, 16'h0001, 16'h0001));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, 32'h0000_0001, 16'h0002, 16'h0002));
    cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, 32'h0000_0000, 16'h0000, 16'h0000));

    // Random: mostly runs of in-order adds closed by a cumulative release, with noise in
    // between. The first run starts just below the wrap and overfills the queue.
    run_seq   = 32'hFFFF_FF00;
    ack_lo    = run_seq - 1;
    made      = 0;
    first_run = 1'b1;
    while (made < 200) begin
      if (first_run || $urandom_range(0, 9) < 7) begin
        run_len = first_run ? 40 : $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          if (run_seq == '0)
            run_seq = 32'h1;
          cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_ADD, run_seq,
                                        rtq_pkg::handle_t'($urandom),
                                        rtq_pkg::len_t'($urandom_range(1, 16'hFFFF))));
          step = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 32'h7FFF_0000)
                                              : $urandom_range(1, 1000);
          run_seq = run_seq + step;
          made++;
        end
        // Acknowledge somewhere between the last acknowledgement and the next sequence of the run
        s = ack_lo + $urandom_range(0, run_seq - ack_lo);
        cmds_waiting.push_back(mk_cmd(rtq_pkg::CMD_RELEASE, s, rtq_pkg::handle_t'($urandom),
                                      rtq_pkg::len_t'($urandom)));
        ack_lo = s;
        made++;
        first_run = 1'b0;
      end else begin
        op_bit = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = run_seq - $urandom_range(1, 50);
          default: s = $urandom;
        endcase
        cmds_waiting.push_back(mk_cmd(op_bit ? rtq_pkg::CMD_RELEASE : rtq_pkg::CMD_ADD, s,
                                      rtq_pkg::handle_t'($urandom),
                                      ($urandom_range(0, 3) == 0) ? rtq_pkg::len_t'(0)
                                                                  : rtq_pkg::len_t'($urandom)));
        made++;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every command taken, then every owed beat seen, then quiet cycles to catch
    // stray beats.
    while (cmds_waiting.size() != 0 || start)
      @(posedge clk_i);
    for (int n = 0; n < 4 * QDEPTH + 100 && beats_due.size() != 0; n++)
      @(posedge clk_i);
    repeat (QDEPTH + 8) @(posedge clk_i);

    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
